// ----- hw/rtl/order_book_level_table_assert.svh -----
// Assertion macros for the order book level table checker.
// Needs a clk in the scope of each use, and an active-low rst_n for OBL_ASSERT.
`ifndef ORDER_BOOK_LEVEL_TABLE_ASSERT_SVH
`define ORDER_BOOK_LEVEL_TABLE_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define OBL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define OBL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/obl_pkg.sv -----
// Shared types and codes for the order book level table.
// Used by obl_front, obl_queue, obl_back and the top level; no dependencies.
package obl_pkg;

    // Port widths
    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;

    // Short queue between front and back
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;

    // Operation codes on the input
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_CANCEL = 2'd1;
    localparam logic [1:0] FN_FILL   = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_UNKNOWN = 3'd1;
    localparam logic [2:0] ST_OVERFILL = 3'd2;
    localparam logic [2:0] ST_DUP     = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // Order states
    localparam logic [1:0] OS_RESTING  = 2'd0;
    localparam logic [1:0] OS_PARTIAL  = 2'd1;
    localparam logic [1:0] OS_FILLED   = 2'd2;
    localparam logic [1:0] OS_CANCELED = 2'd3;

    typedef enum logic [1:0] {
        KD_INSERT,
        KD_CANCEL,
        KD_FILL,
        KD_NOP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] order_id;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
    } item_t;

    typedef struct packed {
        logic [6:0]  side_levels;
        logic [9:0]  level_orders;
        logic [5:0]  level_position;
        logic [31:0] qty_left;
        logic [1:0]  order_state;
        logic [2:0]  status;
    } result_t;

    typedef enum logic [1:0] {
        MD_REPORT,
        MD_INSERT,
        MD_DROP
    } mode_t;

    typedef enum logic [3:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_SCAN,
        BS_DECIDE,
        BS_LRD,
        BS_LCHK,
        BS_APPLY,
        BS_SURD,
        BS_SUWR,
        BS_SDRD,
        BS_SDWR,
        BS_FIN
    } bstate_t;

endpackage

// ----- hw/rtl/order_book_level_table.sv -----
// Top level of the order book level table: front end, queue and back end.
// Depends on obl_pkg, obl_front, obl_queue and obl_back.
//
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  order operation item
// m_*       out  m_tvalid/m_tready  status and level report item
//
// An item goes from the queue through the order slot scan, which reads one slot a cycle;
// most items then take a sorted level search, and opening or dropping a level shifts
// the levels behind it, before the result reaches the output register.
// After reset a clearing pass writes every slot of the slot memory and
// no item is accepted until it ends. A stalled output holds while the queue fills.
module order_book_level_table
#(
    parameter int MAX_LEVELS = 64,
    parameter int MAX_ORDERS = 512,
    parameter int PRICE_BITS = 32,
    parameter int QTY_BITS   = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // order_id[31:0], side[32], price[64:33], quantity[96:65], zero fill
    input  logic [obl_pkg::IN_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [obl_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[2:0], order_state[4:3], qty_left[36:5], level_position[42:37],
    // level_orders[52:43], side_levels[59:53], zero fill
    output logic [obl_pkg::OUT_DATA_W-1:0] m_tdata
);

    logic           clearing;
    logic           push, push_ready, pop, pop_valid;
    obl_pkg::item_t push_item, pop_item;

    obl_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (!clearing),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    obl_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item)
    );

    obl_back
    #(
        .MAX_LEVELS (MAX_LEVELS),
        .MAX_ORDERS (MAX_ORDERS),
        .PRICE_BITS (PRICE_BITS),
        .QTY_BITS   (QTY_BITS)
    )
    u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (clearing),
        .q_valid  (pop_valid),
        .q_item   (pop_item),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- hw/rtl/obl_front.sv -----
// Front end: accepts input items, classifies the operation and hands them on.
// Depends on obl_pkg.
module obl_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        enable,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [obl_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [obl_pkg::IN_USER_W-1:0] s_tuser,
    output logic                        push,
    output obl_pkg::item_t              push_item,
    input  logic                        push_ready
);

    logic           v_reg, v_next;
    obl_pkg::item_t item_reg;
    obl_pkg::kind_t kind;

    // Classify the operation code
    always_comb
    begin
        unique case (s_tuser)
            obl_pkg::FN_INSERT: kind = obl_pkg::KD_INSERT;
            obl_pkg::FN_CANCEL: kind = obl_pkg::KD_CANCEL;
            obl_pkg::FN_FILL:   kind = obl_pkg::KD_FILL;
            default:            kind = obl_pkg::KD_NOP;
        endcase
    end

    assign push      = v_reg && push_ready;
    assign push_item = item_reg;
    assign s_tready  = enable && (!v_reg || push_ready);

    always_comb
    begin
        v_next = v_reg;
        if (push)
        begin
            v_next = 1'b0;
        end
        if (s_tvalid && s_tready)
        begin
            v_next = 1'b1;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    // Capture the classified item
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.kind     <= kind;
            item_reg.order_id <= s_tdata[31:0];
            item_reg.side     <= s_tdata[32];
            item_reg.price    <= s_tdata[64:33];
            item_reg.quantity <= s_tdata[96:65];
        end
    end

endmodule

// ----- hw/rtl/obl_queue.sv -----
// Short queue of classified items between front and back.
// Depends on obl_pkg.
module obl_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  obl_pkg::item_t push_item,
    output logic           push_ready,
    input  logic           pop,
    output logic           pop_valid,
    output obl_pkg::item_t pop_item
);

    obl_pkg::item_t             mem_reg [obl_pkg::QDEPTH];
    logic [obl_pkg::QAW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [obl_pkg::QAW:0]      cnt_reg, cnt_next;

    assign push_ready = (cnt_reg != (obl_pkg::QAW+1)'(obl_pkg::QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem_reg[rp_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = wp_reg + 1'b1;
        end
        if (pop && pop_valid)
        begin
            rp_next = rp_reg + 1'b1;
        end
        if (push && !(pop && pop_valid))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && pop && pop_valid)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store pushed items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= push_item;
        end
    end

endmodule

// ----- hw/rtl/obl_back.sv -----
// Back end: order slot scan, sorted level search and shifting, result register.
// Depends on obl_pkg.
module obl_back
#(
    parameter int MAX_LEVELS = 64,
    parameter int MAX_ORDERS = 512,
    parameter int PRICE_BITS = 32,
    parameter int QTY_BITS   = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    output logic                           clearing,
    input  logic                           q_valid,
    input  obl_pkg::item_t                 q_item,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [obl_pkg::OUT_DATA_W-1:0] m_tdata
);

    localparam int SAW  = $clog2(MAX_ORDERS);
    localparam int SCW  = $clog2(MAX_ORDERS + 1);
    localparam int LAW  = $clog2(MAX_LEVELS);
    localparam int LCW  = $clog2(MAX_LEVELS + 1);
    localparam int CNTW = $clog2(MAX_ORDERS + 1);

    typedef struct packed {
        logic                  valid;
        logic [31:0]           id;
        logic                  side;
        logic [PRICE_BITS-1:0] price;
        logic [QTY_BITS-1:0]   qty;
        logic                  partial;
    } slot_t;

    typedef struct packed {
        logic [PRICE_BITS-1:0] price;
        logic [CNTW-1:0]       count;
    } lvl_t;

    // Memories
    slot_t slot_mem [MAX_ORDERS];
    lvl_t  lvl_mem  [2**(LAW+1)];

    logic            slot_we;
    logic [SAW-1:0]  slot_waddr, slot_raddr;
    slot_t           slot_wdata, slot_rdata;
    logic            lvl_we;
    logic [LAW:0]    lvl_waddr, lvl_raddr;
    lvl_t            lvl_wdata, lvl_rdata;

    obl_pkg::bstate_t state_reg, state_next;
    obl_pkg::item_t   item_reg, item_next;
    obl_pkg::mode_t   mode_reg, mode_next;
    logic [2:0]       st_reg, st_next;
    logic [1:0]       os_reg, os_next;
    logic [SCW-1:0]   scan_reg, scan_next;
    logic             pend_reg, pend_next;
    logic [SAW-1:0]   ridx_reg, ridx_next;
    logic             hit_reg, hit_next;
    logic [SAW-1:0]   hidx_reg, hidx_next;
    slot_t            hent_reg, hent_next;
    logic             free_reg, free_next;
    logic [SAW-1:0]   fidx_reg, fidx_next;
    logic             lside_reg, lside_next;
    logic [PRICE_BITS-1:0] lprice_reg, lprice_next;
    logic [LCW-1:0]   li_reg, li_next;
    logic [LCW-1:0]   pos_reg, pos_next;
    logic             match_reg, match_next;
    logic [CNTW-1:0]  lcnt_reg, lcnt_next;
    logic [LCW-1:0]   bid_depth_reg, bid_depth_next;
    logic [LCW-1:0]   ask_depth_reg, ask_depth_next;
    obl_pkg::result_t res_reg, res_next;
    obl_pkg::result_t out_reg, out_next;
    logic             out_v_reg, out_v_next;

    logic [PRICE_BITS-1:0] in_price;
    logic [QTY_BITS-1:0]   in_qty;
    logic [LCW-1:0]        cur_depth, li_dn, li_up;
    logic [QTY_BITS-1:0]   new_qty;
    logic [CNTW-1:0]       dec_cnt;
    logic                  better;

    assign in_price  = PRICE_BITS'(item_reg.price);
    assign in_qty    = QTY_BITS'(item_reg.quantity);
    assign cur_depth = lside_reg ? ask_depth_reg : bid_depth_reg;
    assign li_dn     = li_reg - LCW'(1);
    assign li_up     = li_reg + LCW'(1);
    assign new_qty   = hent_reg.qty - in_qty;
    assign dec_cnt   = (lcnt_reg != '0) ? lcnt_reg - CNTW'(1) : lcnt_reg;
    assign better    = lside_reg ? (lvl_rdata.price < lprice_reg)
                                 : (lvl_rdata.price > lprice_reg);

    assign clearing = (state_reg == obl_pkg::BS_CLEAR);
    assign m_tvalid = out_v_reg;
    assign m_tdata  = obl_pkg::OUT_DATA_W'(out_reg);

    // Sequence one item through scan, level search and update
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        mode_next      = mode_reg;
        st_next        = st_reg;
        os_next        = os_reg;
        scan_next      = scan_reg;
        pend_next      = 1'b0;
        ridx_next      = ridx_reg;
        hit_next       = hit_reg;
        hidx_next      = hidx_reg;
        hent_next      = hent_reg;
        free_next      = free_reg;
        fidx_next      = fidx_reg;
        lside_next     = lside_reg;
        lprice_next    = lprice_reg;
        li_next        = li_reg;
        pos_next       = pos_reg;
        match_next     = match_reg;
        lcnt_next      = lcnt_reg;
        bid_depth_next = bid_depth_reg;
        ask_depth_next = ask_depth_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_v_next     = out_v_reg;
        q_pop          = 1'b0;
        slot_we        = 1'b0;
        slot_waddr     = hidx_reg;
        slot_wdata     = hent_reg;
        slot_raddr     = scan_reg[SAW-1:0];
        lvl_we         = 1'b0;
        lvl_waddr      = {lside_reg, pos_reg[LAW-1:0]};
        lvl_wdata      = lvl_rdata;
        lvl_raddr      = {lside_reg, li_reg[LAW-1:0]};

        if (out_v_reg && m_tready)
        begin
            out_v_next = 1'b0;
        end

        unique case (state_reg)
            obl_pkg::BS_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = scan_reg[SAW-1:0];
                slot_wdata = '0;
                scan_next  = scan_reg + SCW'(1);
                if (scan_reg == SCW'(MAX_ORDERS - 1))
                begin
                    scan_next  = '0;
                    state_next = obl_pkg::BS_IDLE;
                end
            end
            obl_pkg::BS_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    scan_next  = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    state_next = obl_pkg::BS_SCAN;
                end
            end
            obl_pkg::BS_SCAN:
            begin
                // Issue one slot read a cycle, check the one returned
                if (scan_reg < SCW'(MAX_ORDERS))
                begin
                    pend_next = 1'b1;
                    ridx_next = scan_reg[SAW-1:0];
                    scan_next = scan_reg + SCW'(1);
                end
                else if (!pend_reg)
                begin
                    state_next = obl_pkg::BS_DECIDE;
                end
                if (pend_reg)
                begin
                    if (slot_rdata.valid && slot_rdata.id == item_reg.order_id && !hit_reg)
                    begin
                        hit_next  = 1'b1;
                        hidx_next = ridx_reg;
                        hent_next = slot_rdata;
                    end
                    if (!slot_rdata.valid && !free_reg)
                    begin
                        free_next = 1'b1;
                        fidx_next = ridx_reg;
                    end
                end
            end
            obl_pkg::BS_DECIDE:
            begin
                li_next    = '0;
                res_next   = '0;
                state_next = obl_pkg::BS_LRD;
                unique case (item_reg.kind)
                    obl_pkg::KD_INSERT:
                    begin
                        if (hit_reg)
                        begin
                            mode_next   = obl_pkg::MD_REPORT;
                            st_next     = obl_pkg::ST_DUP;
                            lside_next  = hent_reg.side;
                            lprice_next = hent_reg.price;
                        end
                        else if (!free_reg)
                        begin
                            res_next.status = obl_pkg::ST_FULL;
                            state_next      = obl_pkg::BS_FIN;
                        end
                        else
                        begin
                            mode_next   = obl_pkg::MD_INSERT;
                            st_next     = obl_pkg::ST_OK;
                            lside_next  = item_reg.side;
                            lprice_next = in_price;
                        end
                    end
                    obl_pkg::KD_CANCEL, obl_pkg::KD_FILL:
                    begin
                        lside_next  = hent_reg.side;
                        lprice_next = hent_reg.price;
                        st_next     = obl_pkg::ST_OK;
                        if (!hit_reg)
                        begin
                            res_next.status = obl_pkg::ST_UNKNOWN;
                            state_next      = obl_pkg::BS_FIN;
                        end
                        else if (item_reg.kind == obl_pkg::KD_CANCEL)
                        begin
                            mode_next = obl_pkg::MD_DROP;
                            os_next   = obl_pkg::OS_CANCELED;
                        end
                        else if (in_qty > hent_reg.qty)
                        begin
                            mode_next = obl_pkg::MD_REPORT;
                            st_next   = obl_pkg::ST_OVERFILL;
                        end
                        else
                        begin
                            hent_next.qty = new_qty;
                            if (new_qty == '0)
                            begin
                                mode_next = obl_pkg::MD_DROP;
                                os_next   = obl_pkg::OS_FILLED;
                            end
                            else
                            begin
                                hent_next.partial = 1'b1;
                                mode_next         = obl_pkg::MD_REPORT;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = obl_pkg::BS_FIN;
                    end
                endcase
            end
            obl_pkg::BS_LRD:
            begin
                // Walk the sorted side to the first level not better than the price
                if (li_reg >= cur_depth)
                begin
                    pos_next   = li_reg;
                    match_next = 1'b0;
                    state_next = obl_pkg::BS_APPLY;
                end
                else
                begin
                    state_next = obl_pkg::BS_LCHK;
                end
            end
            obl_pkg::BS_LCHK:
            begin
                if (better)
                begin
                    li_next    = li_up;
                    state_next = obl_pkg::BS_LRD;
                end
                else
                begin
                    pos_next   = li_reg;
                    match_next = (lvl_rdata.price == lprice_reg);
                    lcnt_next  = lvl_rdata.count;
                    state_next = obl_pkg::BS_APPLY;
                end
            end
            obl_pkg::BS_APPLY:
            begin
                res_next.status         = st_reg;
                res_next.level_position = 6'(pos_reg);
                res_next.side_levels    = 7'(cur_depth);
                state_next              = obl_pkg::BS_FIN;
                unique case (mode_reg)
                    obl_pkg::MD_REPORT:
                    begin
                        res_next.order_state  = hent_reg.partial ? obl_pkg::OS_PARTIAL
                                                                 : obl_pkg::OS_RESTING;
                        res_next.qty_left     = 32'(hent_reg.qty);
                        res_next.level_orders = match_reg ? 10'(lcnt_reg) : 10'd0;
                        if (item_reg.kind == obl_pkg::KD_FILL && st_reg == obl_pkg::ST_OK)
                        begin
                            slot_we = 1'b1;
                        end
                    end
                    obl_pkg::MD_INSERT:
                    begin
                        if (!match_reg && cur_depth >= LCW'(MAX_LEVELS))
                        begin
                            res_next        = '0;
                            res_next.status = obl_pkg::ST_FULL;
                        end
                        else
                        begin
                            slot_we              = 1'b1;
                            slot_waddr           = fidx_reg;
                            slot_wdata.valid     = 1'b1;
                            slot_wdata.id        = item_reg.order_id;
                            slot_wdata.side      = item_reg.side;
                            slot_wdata.price     = in_price;
                            slot_wdata.qty       = in_qty;
                            slot_wdata.partial   = 1'b0;
                            res_next.order_state = obl_pkg::OS_RESTING;
                            res_next.qty_left    = 32'(in_qty);
                            if (match_reg)
                            begin
                                lvl_we                = 1'b1;
                                lvl_wdata.price       = lprice_reg;
                                lvl_wdata.count       = lcnt_reg + CNTW'(1);
                                res_next.level_orders = 10'(lcnt_reg + CNTW'(1));
                            end
                            else
                            begin
                                li_next    = cur_depth;
                                state_next = obl_pkg::BS_SURD;
                            end
                        end
                    end
                    default:
                    begin
                        slot_we               = 1'b1;
                        slot_wdata.valid      = 1'b0;
                        res_next.order_state  = os_reg;
                        res_next.qty_left     = 32'(hent_reg.qty);
                        res_next.level_orders = 10'd0;
                        if (match_reg)
                        begin
                            res_next.level_orders = 10'(dec_cnt);
                            if (dec_cnt != '0)
                            begin
                                lvl_we          = 1'b1;
                                lvl_wdata.price = lprice_reg;
                                lvl_wdata.count = dec_cnt;
                            end
                            else
                            begin
                                li_next    = pos_reg;
                                state_next = obl_pkg::BS_SDRD;
                            end
                        end
                    end
                endcase
            end
            obl_pkg::BS_SURD:
            begin
                // Shift levels up one place to open the insert position
                lvl_raddr = {lside_reg, li_dn[LAW-1:0]};
                if (li_reg > pos_reg)
                begin
                    state_next = obl_pkg::BS_SUWR;
                end
                else
                begin
                    lvl_we                = 1'b1;
                    lvl_wdata.price       = lprice_reg;
                    lvl_wdata.count       = CNTW'(1);
                    res_next.level_orders = 10'd1;
                    res_next.side_levels  = 7'(cur_depth + LCW'(1));
                    if (lside_reg)
                    begin
                        ask_depth_next = ask_depth_reg + LCW'(1);
                    end
                    else
                    begin
                        bid_depth_next = bid_depth_reg + LCW'(1);
                    end
                    state_next = obl_pkg::BS_FIN;
                end
            end
            obl_pkg::BS_SUWR:
            begin
                lvl_we     = 1'b1;
                lvl_waddr  = {lside_reg, li_reg[LAW-1:0]};
                li_next    = li_dn;
                state_next = obl_pkg::BS_SURD;
            end
            obl_pkg::BS_SDRD:
            begin
                // Shift levels down one place over the emptied level
                lvl_raddr = {lside_reg, li_up[LAW-1:0]};
                if (li_up < cur_depth)
                begin
                    state_next = obl_pkg::BS_SDWR;
                end
                else
                begin
                    res_next.side_levels = 7'(cur_depth - LCW'(1));
                    if (lside_reg)
                    begin
                        ask_depth_next = ask_depth_reg - LCW'(1);
                    end
                    else
                    begin
                        bid_depth_next = bid_depth_reg - LCW'(1);
                    end
                    state_next = obl_pkg::BS_FIN;
                end
            end
            obl_pkg::BS_SDWR:
            begin
                lvl_we     = 1'b1;
                lvl_waddr  = {lside_reg, li_reg[LAW-1:0]};
                li_next    = li_up;
                state_next = obl_pkg::BS_SDRD;
            end
            obl_pkg::BS_FIN:
            begin
                // Load the output register once it is free
                if (!out_v_reg || m_tready)
                begin
                    out_next   = res_reg;
                    out_v_next = 1'b1;
                    state_next = obl_pkg::BS_IDLE;
                end
            end
            default:
            begin
                state_next = obl_pkg::BS_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= obl_pkg::BS_CLEAR;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            bid_depth_reg <= '0;
            ask_depth_reg <= '0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            bid_depth_reg <= bid_depth_next;
            ask_depth_reg <= ask_depth_next;
            out_v_reg     <= out_v_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        mode_reg   <= mode_next;
        st_reg     <= st_next;
        os_reg     <= os_next;
        ridx_reg   <= ridx_next;
        hit_reg    <= hit_next;
        hidx_reg   <= hidx_next;
        hent_reg   <= hent_next;
        free_reg   <= free_next;
        fidx_reg   <= fidx_next;
        lside_reg  <= lside_next;
        lprice_reg <= lprice_next;
        li_reg     <= li_next;
        pos_reg    <= pos_next;
        match_reg  <= match_next;
        lcnt_reg   <= lcnt_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    // Order slot memory
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata <= slot_mem[slot_raddr];
    end

    // Price level memory, bids in the lower half and asks in the upper
    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            lvl_mem[lvl_waddr] <= lvl_wdata;
        end
        lvl_rdata <= lvl_mem[lvl_raddr];
    end

endmodule

// ----- hw/rtl/obl_checker.sv -----
// Port-level checks for the order book level table, bound to the top level.
// Depends on obl_pkg and order_book_level_table_assert.svh.
`include "order_book_level_table_assert.svh"

module obl_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [obl_pkg::IN_DATA_W-1:0]  s_tdata,
    input logic [obl_pkg::IN_USER_W-1:0]  s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [obl_pkg::OUT_DATA_W-1:0] m_tdata
);

    // Hold a stalled result
    `OBL_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Drop all detail on unknown id and table full
    `OBL_ASSERT(a_err_zero, m_tvalid && (m_tdata[2:0] == obl_pkg::ST_UNKNOWN || m_tdata[2:0] == obl_pkg::ST_FULL) |-> m_tdata[59:3] == '0, "error result carries detail")

    // Rejected operations leave the order resting or partially filled
    `OBL_ASSERT(a_rej_rest, m_tvalid && (m_tdata[2:0] == obl_pkg::ST_OVERFILL || m_tdata[2:0] == obl_pkg::ST_DUP) |-> !m_tdata[4], "rejected order reported removed")

    // No result and no input accepted during reset
    `OBL_ASSERT_ALWAYS(a_rst_quiet, !rst_n |-> !m_tvalid && !s_tready, "handshake active in reset")

endmodule

bind order_book_level_table obl_checker u_obl_checker (.*);
